// File: sv/ipr_pkg.sv
// Package for the image packet reassembly tracker.
// Holds shared types, operation and register codes, and the flag-word search helper.
// No dependencies.
package ipr_pkg;

  localparam int MAX_PACKETS_DEF = 32768;
  localparam int TRAILER_EXTRA_DEF = 64;
  localparam int FLAG_WORD = 32;

  typedef enum logic [1:0] {
    OP_START  = 2'd0,
    OP_PACKET = 2'd1,
    OP_STALL  = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    PH_IDLE    = 2'd0,
    PH_ARMED   = 2'd1,
    PH_READOUT = 2'd2,
    PH_DONE    = 2'd3
  } phase_t;

  localparam logic [2:0] CFG_PAYLOAD_LEN  = 3'd0;
  localparam logic [2:0] CFG_PACKET_TOTAL = 3'd1;
  localparam logic [2:0] CFG_IMAGE_BYTES  = 3'd2;
  localparam logic [2:0] CFG_HEADER_LEN   = 3'd3;
  localparam logic [2:0] CFG_PAYLOAD_TYPE = 3'd4;
  localparam logic [2:0] CFG_TRAILER_TYPE = 3'd5;

  typedef struct packed {
    logic [15:0] payload_len;
    logic [15:0] packet_total;
    logic [27:0] image_bytes;
    logic [7:0]  header_len;
    logic [7:0]  payload_type_code;
    logic [7:0]  trailer_type_code;
  } cfg_t;

  typedef struct packed {
    op_t         op;
    logic [15:0] frame_number;
    logic [23:0] packet_number;
    logic [7:0]  packet_kind;
    logic [15:0] datagram_len;
  } item_t;

  typedef struct packed {
    logic        in_readout;
    logic        image_ready;
    logic [15:0] resend_last;
    logic [15:0] resend_first;
    logic [15:0] resend_frame;
    logic        resend_valid;
    logic [15:0] store_len;
    logic [27:0] store_offset;
    logic        store_valid;
  } result_t;

  // Lowest set bit of a flag word: {found, position}.
  function automatic logic [5:0] first_set(input logic [31:0] v);
    logic [5:0] res;
    res = 6'd0;
    for (int i = 31; i >= 0; i--) begin
      if (v[i]) begin
        res = {1'b1, 5'(i)};
      end
    end
    return res;
  endfunction

endpackage

// File: sv/ipr_ram.sv
// Generic simple dual-port RAM with registered read data.
// One write port and one read port; no dependencies.
module ipr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024,
  parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: sv/ipr_front.sv
// Front end of the tracker: takes input transfers, classifies the operation
// and holds them in a two-entry queue for the back end. Uses ipr_pkg.
module ipr_front
  import ipr_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_op,
  input  logic [63:0] in_data,
  output logic        q_valid,
  input  logic        q_ready,
  output item_t       q_item
);

  item_t      slots [2];
  logic       wp;
  logic       rp;
  logic [1:0] count;
  item_t      incoming;
  logic       push;
  logic       pop;

  always_comb begin
    incoming.op            = op_t'(in_op);
    incoming.frame_number  = in_data[15:0];
    incoming.packet_number = in_data[39:16];
    incoming.packet_kind   = in_data[47:40];
    incoming.datagram_len  = in_data[63:48];
  end

  assign in_ready = (count != 2'd2);
  assign q_valid  = (count != 2'd0);
  assign q_item   = slots[rp];
  assign push     = in_valid && in_ready;
  assign pop      = q_valid && q_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wp] <= incoming;
    end
    if (rst) begin
      wp    <= 1'b0;
      rp    <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) begin
        wp <= ~wp;
      end
      if (pop) begin
        rp <= ~rp;
      end
      count <= count + 2'(push) - 2'(pop);
    end
  end

endmodule

// File: sv/ipr_back.sv
// Back end of the tracker: runs each queued operation against the flag RAM,
// keeps capture state, scans for missing runs and holds the result. Uses ipr_pkg.
module ipr_back
  import ipr_pkg::*;
#(
  parameter int MAX_PACKETS = MAX_PACKETS_DEF,
  parameter int TRAILER_EXTRA_BYTES = TRAILER_EXTRA_DEF,
  parameter int ROWS = (MAX_PACKETS + FLAG_WORD - 1) / FLAG_WORD,
  parameter int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1
) (
  input  logic                 clk,
  input  logic                 rst,
  input  cfg_t                 cfg,
  input  logic                 q_valid,
  output logic                 q_ready,
  input  item_t                q_item,
  output logic                 ram_we,
  output logic [ROW_W-1:0]     ram_waddr,
  output logic [FLAG_WORD-1:0] ram_wdata,
  output logic                 ram_re,
  output logic [ROW_W-1:0]     ram_raddr,
  input  logic [FLAG_WORD-1:0] ram_rdata,
  output logic                 out_valid,
  input  logic                 out_ready,
  output result_t              out_res
);

  localparam int IDX_W = (MAX_PACKETS > 1) ? $clog2(MAX_PACKETS) : 1;
  localparam int PW = IDX_W + 16;
  localparam int MW = (PW > 28) ? PW : 28;

  typedef enum logic [2:0] {
    S_CLR, S_IDLE, S_PRD, S_PACC, S_SRD, S_SEV, S_FIN
  } state_t;

  state_t      state;
  logic [ROW_W-1:0] clr_row;
  logic [ROW_W-1:0] sc_row;
  logic        sc_mode;
  phase_t      phase;
  logic [27:0] bytes_rcv;
  logic [15:0] lframe;
  logic [23:0] prev_pkt;
  logic [23:0] prev_old;
  item_t       cur;
  logic        p_store;
  logic [27:0] p_off;
  logic [15:0] p_len;
  logic        p_resend;
  logic [15:0] p_first;
  logic [15:0] p_last;

  logic [23:0] span;
  logic [23:0] q_pm1;
  logic        q_in_range;
  logic [23:0] c_pm1;
  logic [4:0]  c_bit;
  logic        c_has;
  logic        c_last;
  logic [8:0]  c_strip;
  logic        c_len_ok;
  logic [15:0] c_plen;
  logic        c_accept;
  logic [MW-1:0] c_prod;
  logic [28:0] c_sum;
  logic [23:0] base;
  logic [23:0] rem;
  logic [31:0] vmask;
  logic        row_end;
  logic [5:0]  fz;
  logic [31:0] ones;
  logic [5:0]  fo;
  logic [31:0] hi_mask;
  logic        load;

  assign span = (24'(cfg.packet_total) < 24'(MAX_PACKETS)) ?
                24'(cfg.packet_total) : 24'(MAX_PACKETS);
  assign q_pm1 = q_item.packet_number - 24'd1;
  assign q_in_range = (q_item.packet_number != 24'd0) && (q_item.packet_number <= span);

  assign c_pm1    = cur.packet_number - 24'd1;
  assign c_bit    = c_pm1[4:0];
  assign c_has    = ram_rdata[c_bit];
  assign c_last   = (cur.packet_number == 24'(cfg.packet_total));
  assign c_strip  = 9'(cfg.header_len) + (c_last ? 9'(TRAILER_EXTRA_BYTES) : 9'd0);
  assign c_len_ok = (17'(cur.datagram_len) >= 17'(c_strip));
  assign c_plen   = cur.datagram_len - 16'(c_strip);
  assign c_accept = !c_has && c_len_ok && (c_last || (c_plen == cfg.payload_len));
  assign c_prod   = MW'(c_pm1[IDX_W-1:0]) * MW'(cfg.payload_len);
  assign c_sum    = 29'(bytes_rcv) + 29'(c_plen);

  // Flag word under scan: bits past the frame's last packet are masked off.
  assign base    = 24'({sc_row, 5'd0});
  assign rem     = span - base;
  assign vmask   = (rem >= 24'd32) ? 32'hFFFF_FFFF : ((32'd1 << rem[4:0]) - 32'd1);
  assign row_end = ((base + 24'd32) >= span);
  assign fz      = first_set(~ram_rdata & vmask);
  assign hi_mask = sc_mode ? 32'hFFFF_FFFF : ~((32'd2 << fz[4:0]) - 32'd1);
  assign ones    = (ram_rdata | ~vmask) & hi_mask;
  assign fo      = first_set(ones);

  assign load    = (state == S_FIN) && (!out_valid || out_ready);
  assign q_ready = (state == S_IDLE);

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = clr_row;
    ram_wdata = '0;
    ram_re    = 1'b0;
    ram_raddr = sc_row;
    unique case (state)
      S_CLR: begin
        ram_we = 1'b1;
      end
      S_IDLE: begin
        ram_re    = q_valid && (q_item.op == OP_PACKET) && q_in_range;
        ram_raddr = q_pm1[ROW_W+4:5];
      end
      S_PRD: begin
        ram_we    = c_accept;
        ram_waddr = c_pm1[ROW_W+4:5];
        ram_wdata = ram_rdata | (32'd1 << c_bit);
      end
      S_SRD: begin
        ram_re = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLR;
      clr_row   <= '0;
      sc_row    <= '0;
      sc_mode   <= 1'b0;
      phase     <= PH_IDLE;
      bytes_rcv <= '0;
      lframe    <= '0;
      prev_pkt  <= '0;
      prev_old  <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_ready && !load) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_CLR: begin
          clr_row <= clr_row + ROW_W'(1);
          if (clr_row == ROW_W'(ROWS - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          sc_row   <= '0;
          sc_mode  <= 1'b0;
          p_store  <= 1'b0;
          p_off    <= '0;
          p_len    <= '0;
          p_resend <= 1'b0;
          p_first  <= '0;
          p_last   <= '0;
          if (q_valid) begin
            cur <= q_item;
            unique case (q_item.op)
              OP_START: begin
                phase     <= PH_ARMED;
                bytes_rcv <= '0;
                lframe    <= '0;
                prev_pkt  <= '0;
                state     <= S_FIN;
              end
              OP_PACKET: begin
                if (phase == PH_ARMED || phase == PH_READOUT) begin
                  phase    <= PH_READOUT;
                  lframe   <= q_item.frame_number;
                  prev_old <= prev_pkt;
                  prev_pkt <= q_item.packet_number;
                  if (q_item.packet_kind == cfg.payload_type_code) begin
                    state <= q_in_range ? S_PRD : S_FIN;
                  end else if (q_item.packet_kind == cfg.trailer_type_code) begin
                    state <= S_SRD;
                  end else begin
                    state <= S_FIN;
                  end
                end else begin
                  state <= S_FIN;
                end
              end
              OP_STALL: begin
                state <= (phase == PH_READOUT) ? S_SRD : S_FIN;
              end
              default: begin
                state <= S_FIN;
              end
            endcase
          end
        end
        S_PRD: begin
          if (c_accept) begin
            p_store   <= 1'b1;
            p_len     <= c_plen;
            p_off     <= c_prod[27:0];
            bytes_rcv <= c_sum[28] ? 28'hFFF_FFFF : c_sum[27:0];
            state     <= S_PACC;
          end else begin
            state <= S_FIN;
          end
        end
        S_PACC: begin
          if (bytes_rcv == cfg.image_bytes) begin
            phase <= PH_DONE;
            state <= S_FIN;
          end else if (cur.packet_number != prev_old + 24'd1) begin
            state <= S_SRD;
          end else begin
            state <= S_FIN;
          end
        end
        S_SRD: begin
          state <= S_SEV;
        end
        S_SEV: begin
          if (!sc_mode) begin
            if (fz[5]) begin
              p_first <= 16'(base + 24'(fz[4:0]) + 24'd1);
              if (fo[5]) begin
                p_last   <= 16'(base + 24'(fo[4:0]));
                p_resend <= 1'b1;
                state    <= S_FIN;
              end else if (row_end) begin
                p_last   <= 16'(span);
                p_resend <= 1'b1;
                state    <= S_FIN;
              end else begin
                sc_mode <= 1'b1;
                sc_row  <= sc_row + ROW_W'(1);
                state   <= S_SRD;
              end
            end else if (row_end) begin
              state <= S_FIN;
            end else begin
              sc_row <= sc_row + ROW_W'(1);
              state  <= S_SRD;
            end
          end else begin
            if (fo[5]) begin
              p_last   <= 16'(base + 24'(fo[4:0]));
              p_resend <= 1'b1;
              state    <= S_FIN;
            end else if (row_end) begin
              p_last   <= 16'(span);
              p_resend <= 1'b1;
              state    <= S_FIN;
            end else begin
              sc_row <= sc_row + ROW_W'(1);
              state  <= S_SRD;
            end
          end
        end
        S_FIN: begin
          if (load) begin
            out_valid <= 1'b1;
            clr_row   <= '0;
            state     <= (cur.op == OP_START) ? S_CLR : S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_res.store_valid  <= p_store;
      out_res.store_offset <= p_off;
      out_res.store_len    <= p_len;
      out_res.resend_valid <= p_resend;
      out_res.resend_frame <= p_resend ? lframe : 16'd0;
      out_res.resend_first <= p_first & {16{p_resend}};
      out_res.resend_last  <= p_last & {16{p_resend}};
      out_res.image_ready  <= (phase == PH_DONE);
      out_res.in_readout   <= (phase == PH_READOUT);
    end
  end

  a_no_pop_in_clear : assert property (@(posedge clk) disable iff (rst)
    (state == S_CLR) |-> !(q_valid && q_ready))
    else $error("queue popped during flag clear");

  a_done_no_resend : assert property (@(posedge clk) disable iff (rst)
    (load && p_store && phase == PH_DONE) |-> !p_resend)
    else $error("resend issued on completing packet");

  a_no_rw_overlap : assert property (@(posedge clk) disable iff (rst)
    ram_we |-> !ram_re)
    else $error("flag RAM read and write in the same cycle");

  a_hold_result : assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_res)))
    else $error("pending result changed before transfer");

endmodule

// File: sv/image_packet_reassembly_tracker_top.sv
// Top level of the image packet reassembly tracker.
// Holds the configuration registers and joins ipr_front, ipr_back and ipr_ram; uses ipr_pkg.
//
// Channel   Direction  Handshake                     Payload
// s_axis    in         s_axis_tvalid/s_axis_tready   tuser operation, tdata header fields
// m_axis    out        m_axis_tvalid/m_axis_tready   tdata one result per input transfer
// cfg       in         cfg_we                        cfg_index, cfg_data
//
// A start passes through the back end, then a clear pass runs over the (MAX_PACKETS+31)/32
// words of the flag RAM, one 32-bit flag word per cycle; the same pass runs after reset.
// An ignored packet goes straight to the result, a rejected or duplicate payload first
// reads its flag word, and an accepted payload also sets its flag and checks the byte
// count; a scan does a RAM read, then a search, per flag word and visits each at most once.
// Reset is synchronous and active high. The input queue holds two transfers and the
// result register lets the back end finish while the output is stalled.
module image_packet_reassembly_tracker_top
  import ipr_pkg::*;
#(
  parameter int MAX_PACKETS = MAX_PACKETS_DEF,
  parameter int TRAILER_EXTRA_BYTES = TRAILER_EXTRA_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // tdata: frame_number[15:0], packet_number[39:16], packet_kind[47:40],
  //        datagram_len[63:48]
  input  logic [63:0] s_axis_tdata,
  // tuser: operation[1:0]
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // tdata: store_valid[0], store_offset[28:1], store_len[44:29], resend_valid[45],
  //        resend_frame[61:46], resend_first[77:62], resend_last[93:78],
  //        image_ready[94], in_readout[95]
  output logic [95:0] m_axis_tdata,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [27:0] cfg_data
);

  localparam int ROWS = (MAX_PACKETS + FLAG_WORD - 1) / FLAG_WORD;
  localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;

  cfg_t    cfg;
  item_t   q_item;
  logic    q_valid;
  logic    q_ready;
  logic    ram_we;
  logic    ram_re;
  logic [ROW_W-1:0] ram_waddr;
  logic [ROW_W-1:0] ram_raddr;
  logic [FLAG_WORD-1:0] ram_wdata;
  logic [FLAG_WORD-1:0] ram_rdata;
  result_t res;

  // Configuration registers; the user must write them only while the block is idle; the block does not enforce this.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.payload_len       <= 16'd1464;
      cfg.packet_total      <= 16'd1;
      cfg.image_bytes       <= 28'd1;
      cfg.header_len        <= 8'd8;
      cfg.payload_type_code <= 8'd3;
      cfg.trailer_type_code <= 8'd2;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_PAYLOAD_LEN:  cfg.payload_len       <= cfg_data[15:0];
        CFG_PACKET_TOTAL: cfg.packet_total      <= cfg_data[15:0];
        CFG_IMAGE_BYTES:  cfg.image_bytes       <= cfg_data;
        CFG_HEADER_LEN:   cfg.header_len        <= cfg_data[7:0];
        CFG_PAYLOAD_TYPE: cfg.payload_type_code <= cfg_data[7:0];
        CFG_TRAILER_TYPE: cfg.trailer_type_code <= cfg_data[7:0];
        default: begin
        end
      endcase
    end
  end

  ipr_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .in_op    (s_axis_tuser),
    .in_data  (s_axis_tdata),
    .q_valid  (q_valid),
    .q_ready  (q_ready),
    .q_item   (q_item)
  );

  ipr_back #(
    .MAX_PACKETS         (MAX_PACKETS),
    .TRAILER_EXTRA_BYTES (TRAILER_EXTRA_BYTES),
    .ROWS                (ROWS),
    .ROW_W               (ROW_W)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .q_valid   (q_valid),
    .q_ready   (q_ready),
    .q_item    (q_item),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_re    (ram_re),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_res   (res)
  );

  // Received flags, 32 packets per word; packet n sits at bit n-1.
  ipr_ram #(
    .WIDTH (FLAG_WORD),
    .DEPTH (ROWS),
    .AW    (ROW_W)
  ) u_flags (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_en   (ram_re),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  assign m_axis_tdata = res;

endmodule

// File: test/image_packet_reassembly_tracker_top_tb.sv
// Self-checking testbench for image_packet_reassembly_tracker_top.
// Uses ipr_pkg for the operation codes, register indexes and transfer layouts.
`timescale 1ns / 1ps

module image_packet_reassembly_tracker_top_tb;
  import ipr_pkg::*;

  localparam int FLAG_COUNT = 32768;
  localparam int TRAILER_BYTES = 64;
  localparam int SETTLE_CYCLES = 2500;
  localparam longint CYCLE_LIMIT = 10000000;

  // The frame tracker predictor keeps its own copy of the registers and the flag store.
  class frame_tracker_sb;
    cfg_t    regs;
    bit      got_packet [1:FLAG_COUNT];
    int      byte_count;
    int      frame_seen;
    int      last_number;
    phase_t  phase;
    result_t expected_q[$];
    int      errors;

    function new();
      regs.payload_len = 16'd1464;
      regs.packet_total = 16'd1;
      regs.image_bytes = 28'd1;
      regs.header_len = 8'd8;
      regs.payload_type_code = 8'd3;
      regs.trailer_type_code = 8'd2;
      foreach (got_packet[i]) got_packet[i] = 1'b0;
      byte_count = 0;
      frame_seen = 0;
      last_number = 0;
      phase = PH_IDLE;
      errors = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [27:0] val);
      case (idx)
        CFG_PAYLOAD_LEN:  regs.payload_len = val[15:0];
        CFG_PACKET_TOTAL: regs.packet_total = val[15:0];
        CFG_IMAGE_BYTES:  regs.image_bytes = val;
        CFG_HEADER_LEN:   regs.header_len = val[7:0];
        CFG_PAYLOAD_TYPE: regs.payload_type_code = val[7:0];
        CFG_TRAILER_TYPE: regs.trailer_type_code = val[7:0];
        default: ;
      endcase
    endfunction

    function int span();
      return (regs.packet_total < FLAG_COUNT) ? int'(regs.packet_total) : FLAG_COUNT;
    endfunction

    // Look for the first run of packets that has not arrived yet.
    function bit find_gap(output int first, output int last);
      int a;
      int b;
      a = 1;
      first = 0;
      last = 0;
      while (a <= span() && got_packet[a]) a++;
      if (a > span()) return 1'b0;
      b = a;
      while (b <= span() && !got_packet[b]) b++;
      first = a;
      last = b - 1;
      return 1'b1;
    endfunction

    function void note_item(item_t it);
      result_t r;
      int first;
      int last;
      int pnum;
      int strip;
      int plen;
      longint sum;
      bit is_last;
      r = '0;
      first = 0;
      last = 0;
      pnum = int'(it.packet_number);
      case (it.op)
        OP_START: begin
          foreach (got_packet[i]) got_packet[i] = 1'b0;
          byte_count = 0;
          frame_seen = 0;
          last_number = 0;
          phase = PH_ARMED;
        end
        OP_PACKET: begin
          if (phase == PH_ARMED || phase == PH_READOUT) begin
            phase = PH_READOUT;
            frame_seen = int'(it.frame_number);
            if (it.packet_kind == regs.payload_type_code) begin
              if (pnum >= 1 && pnum <= span() && !got_packet[pnum]) begin
                is_last = (pnum == int'(regs.packet_total));
                strip = int'(regs.header_len) + (is_last ? TRAILER_BYTES : 0);
                if (int'(it.datagram_len) >= strip) begin
                  plen = int'(it.datagram_len) - strip;
                  if (is_last || plen == int'(regs.payload_len)) begin
                    r.store_valid = 1'b1;
                    r.store_offset = 28'(longint'(pnum - 1) * longint'(regs.payload_len));
                    r.store_len = 16'(plen);
                    sum = longint'(byte_count) + plen;
                    byte_count = (sum > 28'hFFFFFFF) ? 28'hFFFFFFF : int'(sum);
                    got_packet[pnum] = 1'b1;
                    if (byte_count == int'(regs.image_bytes)) phase = PH_DONE;
                    else if (pnum != last_number + 1) r.resend_valid = find_gap(first, last);
                  end
                end
              end
            end else if (it.packet_kind == regs.trailer_type_code) begin
              r.resend_valid = find_gap(first, last);
            end
            last_number = pnum;
          end
        end
        OP_STALL: begin
          if (phase == PH_READOUT) r.resend_valid = find_gap(first, last);
        end
        default: ;
      endcase
      if (r.resend_valid) begin
        r.resend_frame = 16'(frame_seen);
        r.resend_first = 16'(first);
        r.resend_last = 16'(last);
      end
      r.image_ready = (phase == PH_DONE);
      r.in_readout = (phase == PH_READOUT);
      expected_q.push_back(r);
    endfunction

    task report(string what, logic [27:0] got, logic [27:0] want);
      $display("mismatch %s: got %0h expected %0h", what, got, want);
      errors++;
    endtask

    task check_result(result_t got);
      result_t want;
      if (expected_q.size() == 0) begin
        report("unexpected transfer", got.store_offset, 0);
        return;
      end
      want = expected_q.pop_front();
      if (got.store_valid !== want.store_valid)
        report("store_valid", got.store_valid, want.store_valid);
      if (got.store_offset !== want.store_offset)
        report("store_offset", got.store_offset, want.store_offset);
      if (got.store_len !== want.store_len) report("store_len", got.store_len, want.store_len);
      if (got.resend_valid !== want.resend_valid)
        report("resend_valid", got.resend_valid, want.resend_valid);
      if (got.resend_frame !== want.resend_frame)
        report("resend_frame", got.resend_frame, want.resend_frame);
      if (got.resend_first !== want.resend_first)
        report("resend_first", got.resend_first, want.resend_first);
      if (got.resend_last !== want.resend_last)
        report("resend_last", got.resend_last, want.resend_last);
      if (got.image_ready !== want.image_ready)
        report("image_ready", got.image_ready, want.image_ready);
      if (got.in_readout !== want.in_readout)
        report("in_readout", got.in_readout, want.in_readout);
    endtask
  endclass

  logic        clk;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata = '0;
  logic [1:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [95:0] m_axis_tdata;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [27:0] cfg_data = '0;

  frame_tracker_sb sb = new();
  longint cycle_count = 0;
  bit     no_gaps = 1'b0;

  // Shape of the frame that the current phase sends.
  int frame_plen;
  int frame_total;
  int frame_hdr;
  int frame_last_len;
  int frame_ptype;
  int frame_ttype;
  int next_number;

  image_packet_reassembly_tracker_top DUT (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Watchdog: a hung handshake or a lost result ends the run here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  function int draw_gap();
    return no_gaps ? 0 : $urandom_range(0, 7);
  endfunction

  // Sends one transfer. Valid stays high across back-to-back transfers, so it is
  // only lowered when a gap is drawn.
  task automatic send_item(item_t it);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= it.op;
    s_axis_tdata <= {it.datagram_len, it.packet_kind, it.packet_number, it.frame_number};
    do @(posedge clk); while (!s_axis_tready);
    sb.note_item(it);
  endtask

  // Before each result the receiver stalls for a randomly drawn gap, which may be zero.
  initial begin : result_sink
    int gap;
    while (rst !== 1'b0) @(posedge clk);
    forever begin
      gap = draw_gap();
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk); while (m_axis_tvalid !== 1'b1);
      sb.check_result(result_t'(m_axis_tdata));
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [27:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    sb.write_reg(idx, val);
  endtask

  // Registers change only once every result is back and the clear pass has had
  // time to finish.
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_frame(int plen, int total, int img, int hdr, int pt, int tt, int last_len);
    wait_idle();
    write_reg(CFG_PAYLOAD_LEN, 28'(plen));
    write_reg(CFG_PACKET_TOTAL, 28'(total));
    write_reg(CFG_IMAGE_BYTES, 28'(img));
    write_reg(CFG_HEADER_LEN, 28'(hdr));
    write_reg(CFG_PAYLOAD_TYPE, 28'(pt));
    write_reg(CFG_TRAILER_TYPE, 28'(tt));
    cfg_we <= 1'b0;
    frame_plen = plen;
    frame_total = total;
    frame_hdr = hdr;
    frame_ptype = pt;
    frame_ttype = tt;
    frame_last_len = last_len;
    next_number = 1;
  endtask

  function automatic item_t mk(op_t op, int frame, int pnum, int kind, int dlen);
    item_t it;
    it.op = op;
    it.frame_number = 16'(frame);
    it.packet_number = 24'(pnum);
    it.packet_kind = 8'(kind);
    it.datagram_len = 16'(dlen);
    return it;
  endfunction

  // Mostly in-order packets of the current frame with occasional skips and
  // repeats, plus trailers, stall ticks, restarts and raw noise.
  task automatic random_frame(int count);
    item_t it;
    int sel;
    int pnum;
    int kind;
    int dlen;
    int frame;
    frame = $urandom_range(0, 65535);
    send_item(mk(OP_START, 0, 0, 0, 0));
    repeat (count) begin
      if ($urandom_range(0, 19) == 0) no_gaps = !no_gaps;
      sel = $urandom_range(0, 99);
      if (sel < 3) begin
        it = mk(OP_START, $urandom, $urandom, $urandom, $urandom);
        next_number = 1;
      end else if (sel < 11) begin
        it = mk(OP_STALL, $urandom, $urandom, $urandom, $urandom);
      end else if (sel < 13) begin
        it = mk(OP_NONE, $urandom, $urandom, $urandom, $urandom);
      end else if (sel < 20) begin
        it = mk(OP_PACKET, $urandom, $urandom, $urandom, $urandom);
      end else begin
        sel = $urandom_range(0, 99);
        if (sel < 70) pnum = next_number;
        else if (sel < 85) pnum = next_number + $urandom_range(1, 3);
        else if (sel < 95) pnum = $urandom_range(1, frame_total);
        else pnum = $urandom_range(0, 1) ? 0 : frame_total + 1;
        next_number = (pnum >= frame_total) ? 1 : pnum + 1;
        sel = $urandom_range(0, 99);
        kind = (sel < 85) ? frame_ptype : (sel < 95) ? frame_ttype : $urandom_range(0, 255);
        if ($urandom_range(0, 9) == 0) dlen = $urandom_range(0, 65535);
        else if (pnum == frame_total) dlen = frame_hdr + TRAILER_BYTES + frame_last_len;
        else dlen = frame_hdr + frame_plen;
        if ($urandom_range(0, 7) == 0) frame = $urandom_range(0, 65535);
        it = mk(OP_PACKET, frame, pnum, kind, dlen);
      end
      send_item(it);
    end
  endtask

  initial begin : stimulus
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Reset values: one packet of one payload byte makes up the whole image.
    set_frame(1464, 1, 1, 8, 3, 2, 1);
    send_item(mk(OP_PACKET, 16'h1234, 1, 3, 73));             // ignored while idle
    send_item(mk(OP_STALL, 0, 0, 0, 0));                      // stall tick outside readout
    send_item(mk(OP_NONE, 16'hFFFF, 24'hFFFFFF, 255, 65535)); // no operation
    send_item(mk(OP_START, 16'hFFFF, 24'hFFFFFF, 255, 65535));
    send_item(mk(OP_PACKET, 16'hFFFF, 1, 2, 0));              // trailer in armed: scan
    send_item(mk(OP_STALL, 0, 0, 0, 0));                      // stall in readout: scan
    send_item(mk(OP_PACKET, 16'h0001, 0, 3, 73));             // number zero
    send_item(mk(OP_PACKET, 16'h0002, 24'hFFFFFF, 3, 73));    // number too large
    send_item(mk(OP_PACKET, 16'h0003, 1, 3, 71));             // datagram too short
    send_item(mk(OP_PACKET, 16'h0004, 1, 7, 73));             // unknown type
    send_item(mk(OP_PACKET, 16'h0005, 1, 3, 73));             // completes the image
    send_item(mk(OP_PACKET, 16'h0006, 1, 3, 73));             // ignored while done
    send_item(mk(OP_STALL, 0, 0, 0, 0));
    send_item(mk(OP_START, 0, 0, 0, 0));
    send_item(mk(OP_PACKET, 16'h0007, 1, 3, 72));             // empty last packet
    send_item(mk(OP_PACKET, 16'h0008, 1, 3, 72));             // duplicate

    set_frame(16, 8, 7 * 16 + 5, 8, 3, 2, 5);
    random_frame(100);
    // Equal type codes: payload meaning wins.
    set_frame(1, 1, 1, 0, 0, 0, 1);
    random_frame(60);
    // Widest payload, largest image size, zero header.
    set_frame(65535, 4, 28'hFFFFFFF, 0, 255, 254, 100);
    random_frame(80);
    set_frame(100, 40, 39 * 100 + 30, 255, 7, 9, 30);
    random_frame(100);
    // Largest frame; scans walk the whole store.
    set_frame(1464, 32768, 28'hFFFFFFF, 8, 3, 2, 10);
    random_frame(40);
    set_frame(200, 20, 19 * 200, 12, 1, 5, 0);
    random_frame(100);
    set_frame(1464, 1, 1, 8, 3, 2, 1);
    random_frame(100);

    wait_idle();
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
